// ----- rtl/csfr_pkg.sv -----
// ----------------------------------------------------------------------------
// csfr_pkg: shared definitions for the CRC-8 serial frame receiver
// Frame constants, status codes, the result record and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package csfr_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'h55;
  localparam logic [7:0] HDR_SECOND  = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] MIN_PAYLOAD = 8'd7;
  localparam int         MAX_PAYLOAD_DEF = 16;

  // Number of payload bytes that reach the result.
  localparam int         KEEP_BYTES  = 7;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } csfr_status_t;

  typedef struct packed {
    csfr_status_t status;
    logic [7:0]   next_state_code;
    logic [7:0]   take_flag;
    logic [31:0]  yaw_bits;
    logic [7:0]   clean_flag;
  } csfr_result_t;

  // Reflected CRC-8 update of one byte, polynomial 0x8C, one bit per step.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/csfr_out_buf.sv -----
// ----------------------------------------------------------------------------
// csfr_out_buf: two-entry result buffer
// An output register backed by one skid entry, so the parser keeps taking
// bytes while a finished result waits for the consumer.
// ----------------------------------------------------------------------------
module csfr_out_buf
  import csfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  csfr_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output csfr_result_t out_data
);

  logic         out_valid_r;
  logic         skid_valid_r;
  csfr_result_t out_data_r;
  csfr_result_t skid_data_r;
  logic         pop;

  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        out_data_r  <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/crc8_serial_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// crc8_serial_frame_receiver_top: serial frame receiver with CRC-8 check
// Hunts for the 0x55 0xAA header, takes length, payload, CRC and two trailer
// bytes, and reports one result per frame or per detected error.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                 | Direction | Beat carries
//  --------+---------------------------------------+-----------+------------------
//  in      | in_valid, in_ready, in_rx_byte        | input     | one received byte
//  out     | out_valid, out_ready, out_status,     | output    | one frame result
//          | out_next_state_code, out_take_flag,   |           |
//          | out_yaw_bits, out_clean_flag          |           |
//
// Each input beat is handled in the cycle it is accepted: the byte-wide CRC
// update and the frame state update sit between the parser registers, so a
// new byte can be taken on every clock. A result is registered in the result
// buffer as the byte that completes it is accepted. The result side is a
// two-entry buffer; in_ready drops only when both entries hold results, so a
// stalled consumer holds up the input only after two results are pending.
// Reset is synchronous and active low; the receiver leaves reset hunting for
// a header with no result pending.
//
// Frame layout: 0x55 0xAA, length, payload, CRC, two unchecked trailer bytes.
// The CRC (reflected, polynomial 0x8C, initial value 0) covers the header,
// the length and the payload. A length below 7 or above MAX_PAYLOAD reports
// a length error on the length byte; a bad CRC reports a CRC error on the
// CRC byte. In both cases the receiver goes back to hunting. Error results
// carry zero in every payload field.

module crc8_serial_frame_receiver_top
  import csfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_next_state_code,
  output logic [7:0]  out_take_flag,
  output logic [31:0] out_yaw_bits,
  output logic [7:0]  out_clean_flag
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);
  // CRC after the two header bytes, a fixed value.
  localparam logic [7:0] CrcHdr = crc8_update(crc8_update(8'h00, HDR_FIRST), HDR_SECOND);

  // Parser states, one-hot.
  typedef enum logic [4:0] {
    S_HUNT  = 5'b00001,
    S_LEN   = 5'b00010,
    S_PAY   = 5'b00100,
    S_CRC   = 5'b01000,
    S_TRAIL = 5'b10000
  } csfr_state_t;

  csfr_state_t  state_r,    state_nxt;
  logic [7:0]   prev_r,     prev_nxt;
  logic [7:0]   len_r,      len_nxt;
  logic [7:0]   cnt_r,      cnt_nxt;
  logic [7:0]   crc_r,      crc_nxt;
  logic         trail_r,    trail_nxt;

  // Only the first seven payload bytes are ever reported, so only those
  // are kept. Each frame overwrites them before its result is formed.
  logic [7:0]   keep_r [KEEP_BYTES];

  logic         in_acc;
  logic [7:0]   crc_upd;
  logic [7:0]   cnt_inc;
  logic         store_we;
  logic         res_push;
  csfr_result_t res;
  csfr_result_t buf_data;
  logic         buf_full;

  assign in_ready = !buf_full;
  assign in_acc   = in_valid && in_ready;
  assign crc_upd  = crc8_update(crc_r, in_rx_byte);
  assign cnt_inc  = cnt_r + 8'd1;
  assign store_we = in_acc && (state_r == S_PAY) && (cnt_r < 8'(KEEP_BYTES));

  always_comb begin
    state_nxt = state_r;
    prev_nxt  = prev_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    res_push  = 1'b0;
    res       = '0;

    if (in_acc) begin
      case (state_r)
        S_HUNT: begin
          if (in_rx_byte == HDR_SECOND) begin
            if (prev_r == HDR_FIRST) begin
              state_nxt = S_LEN;
              cnt_nxt   = 8'd0;
              trail_nxt = 1'b0;
              crc_nxt   = CrcHdr;
            end
          end else begin
            prev_nxt = in_rx_byte;
          end
        end
        S_LEN: begin
          len_nxt = in_rx_byte;
          crc_nxt = crc_upd;
          if (in_rx_byte < MIN_PAYLOAD || in_rx_byte > MaxLen) begin
            state_nxt  = S_HUNT;
            prev_nxt   = 8'd0;
            cnt_nxt    = 8'd0;
            trail_nxt  = 1'b0;
            res_push   = 1'b1;
            res.status = STATUS_LEN_ERR;
          end else begin
            cnt_nxt   = 8'd0;
            state_nxt = S_PAY;
          end
        end
        S_PAY: begin
          crc_nxt = crc_upd;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            state_nxt = S_CRC;
          end
        end
        S_CRC: begin
          if (in_rx_byte != crc_r) begin
            state_nxt  = S_HUNT;
            prev_nxt   = 8'd0;
            cnt_nxt    = 8'd0;
            trail_nxt  = 1'b0;
            res_push   = 1'b1;
            res.status = STATUS_CRC_ERR;
          end else begin
            trail_nxt = 1'b0;
            state_nxt = S_TRAIL;
          end
        end
        S_TRAIL: begin
          if (!trail_r) begin
            trail_nxt = 1'b1;
          end else begin
            state_nxt           = S_HUNT;
            prev_nxt            = 8'd0;
            cnt_nxt             = 8'd0;
            trail_nxt           = 1'b0;
            res_push            = 1'b1;
            res.status          = STATUS_OK;
            res.next_state_code = keep_r[0];
            res.take_flag       = keep_r[1];
            res.yaw_bits        = {keep_r[5], keep_r[4], keep_r[3], keep_r[2]};
            res.clean_flag      = keep_r[6];
          end
        end
        default: begin
          state_nxt = S_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      prev_r  <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      crc_r   <= 8'd0;
      trail_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      trail_r <= trail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      keep_r[cnt_r[2:0]] <= in_rx_byte;
    end
  end

  csfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_data)
  );

  assign out_status          = buf_data.status;
  assign out_next_state_code = buf_data.next_state_code;
  assign out_take_flag       = buf_data.take_flag;
  assign out_yaw_bits        = buf_data.yaw_bits;
  assign out_clean_flag      = buf_data.clean_flag;

endmodule

// ----- rtl/csfr_checker.sv -----
// ----------------------------------------------------------------------------
// csfr_checker: port-level checks for the frame receiver
// Watches the top-level ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
module csfr_checker
  import csfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_next_state_code,
  input logic [7:0]  out_take_flag,
  input logic [31:0] out_yaw_bits,
  input logic [7:0]  out_clean_flag
);

  // A stalled input beat stays offered with the same byte.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("input beat changed while stalled");

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_yaw_bits) && $stable(out_next_state_code) &&
      $stable(out_take_flag) && $stable(out_clean_flag))
    else $error("result beat changed while stalled");

  // Input backpressure only comes from a pending result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // Error results carry zero payload.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_CRC_ERR || out_status == STATUS_LEN_ERR) |->
      out_next_state_code == 8'd0 && out_take_flag == 8'd0 &&
      out_yaw_bits == 32'd0 && out_clean_flag == 8'd0)
    else $error("error result with nonzero payload");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending after reset");

endmodule

bind crc8_serial_frame_receiver_top csfr_checker u_csfr_checker (.*);
